FILE: hw/rtl/isq_pkg.sv
// Package for the interval set merge/query block.
// Shared types, codes and constants; used by every module of the block.
package isq_pkg;

	localparam int TIME_W          = 16;
	localparam int MAX_SPANS_DEF   = 16;
	localparam int COUNT_OUT_W     = 5;
	localparam logic [TIME_W-1:0] TIME_LIMIT = 16'd49152; // 24 hours, 11 fraction bits

	typedef enum logic [0:0] {
		OP_QUERY = 1'b0,
		OP_ADD   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_ORDER   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture a new item
		logic merge;   // absorb the first touched span and close the gap
		logic commit;  // finish the item and load the result register
	} isq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic merge_pending; // an add still overlaps a stored span
	} isq_sts_t;

endpackage

FILE: hw/rtl/interval_set_merge_query.sv
// Top level of the interval set merge/query block: controller, datapath, port packing.
// Depends on isq_pkg, isq_ctl and isq_dp.
//
// Channel   Dir  Width  Contents
// s_axis    in   32+1   tdata: first_time, last_time; tuser: op
// m_axis    out  8      tdata: is_inside, status, span_count
//
// Sequence: a query, a rejected add or an add that touches no stored span is
// accepted, then evaluated and committed; an add that merges stored spans is
// accepted, absorbs them one per shared compare/shift step of the datapath,
// then commits. One item is in flight at a time.
// Reset: clears the span count and the controller; the table needs no clearing.
// Stalls: a finished result waits in the output register; the next item is
// accepted meanwhile and holds at its commit until that register is free.
module interval_set_merge_query
	import isq_pkg::*;
#(
	parameter int MAX_SPANS = MAX_SPANS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] first_time, [31:16] last_time
	input  logic [0:0]  s_axis_tuser,  // [0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [0] is_inside, [2:1] status, [7:3] span_count
);

	isq_cmd_t                cmd;
	isq_sts_t                sts;
	logic                    res_inside;
	status_t                 res_status;
	logic [COUNT_OUT_W-1:0]  res_count;

	isq_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	isq_dp #(
		.MAX_SPANS (MAX_SPANS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (op_t'(s_axis_tuser[0])),
		.in_first   (s_axis_tdata[15:0]),
		.in_last    (s_axis_tdata[31:16]),
		.res_inside (res_inside),
		.res_status (res_status),
		.res_count  (res_count)
	);

	// pack the result transfer, lowest field first
	assign m_axis_tdata = {res_count, res_status, res_inside};

	// accepting an item always leaves the controller busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in work");

	// a hit is only reported by a valid query
	a_inside_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] == ST_OK)
		else $error("is_inside set with a non-ok status");

	// table full only when the table really holds its capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:1] == ST_FULL |->
		m_axis_tdata[7:3] == COUNT_OUT_W'(MAX_SPANS))
		else $error("table full reported below capacity");

	// stored span count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (MAX_SPANS > 31) || (int'(m_axis_tdata[7:3]) <= MAX_SPANS))
		else $error("span count above capacity");

endmodule

FILE: hw/rtl/isq_ctl.sv
// Controller of the interval set block: item sequencing and result handshake.
// Depends on isq_pkg.
module isq_ctl
	import isq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  isq_sts_t sts,
	output isq_cmd_t cmd
);

	ctl_state_t state_q, state_nx;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				if (sts.merge_pending) begin
					cmd.merge = 1'b1;
				end else if (slot_free) begin
					// hold while the previous result still waits
					cmd.commit = 1'b1;
					state_nx   = CTL_IDLE;
				end
			end
			default: state_nx = CTL_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/isq_dp.sv
// Datapath of the interval set block: span table, parallel compares, merge and insert.
// Depends on isq_pkg.
module isq_dp
	import isq_pkg::*;
#(
	parameter int MAX_SPANS = MAX_SPANS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  isq_cmd_t               cmd,
	output isq_sts_t               sts,
	input  op_t                    in_op,
	input  logic [TIME_W-1:0]      in_first,
	input  logic [TIME_W-1:0]      in_last,
	output logic                   res_inside,
	output status_t                res_status,
	output logic [COUNT_OUT_W-1:0] res_count
);

	localparam int CW = $clog2(MAX_SPANS + 1);

	logic [TIME_W-1:0] start_q [MAX_SPANS];
	logic [TIME_W-1:0] end_q   [MAX_SPANS];
	logic [CW-1:0]     count_q;

	op_t               op_q;
	logic [TIME_W-1:0] ns_q, ne_q;
	logic              first_q;

	logic [MAX_SPANS-1:0] vld, below, touch, pos, hit;
	logic [TIME_W-1:0]    sel_start, sel_end, mrg_start, mrg_end;
	logic                 touched_any, do_insert;
	status_t              status_c;
	logic                 inside_c;
	logic [CW-1:0]        count_nx;

	// per-entry compares against the working span
	always_comb begin
		sel_start = '0;
		sel_end   = '0;
		for (int i = 0; i < MAX_SPANS; i++) begin
			vld[i]   = CW'(i) < count_q;
			below[i] = vld[i] && (end_q[i] < ns_q);
			touch[i] = vld[i] && !below[i] && (start_q[i] <= ne_q);
			hit[i]   = vld[i] && (start_q[i] <= ns_q) && (ns_q <= end_q[i]);
		end
		pos[0] = !below[0];
		for (int i = 1; i < MAX_SPANS; i++) begin
			pos[i] = !below[i] && below[i-1];
		end
		for (int i = 0; i < MAX_SPANS; i++) begin
			if (pos[i]) begin
				sel_start = sel_start | start_q[i];
				sel_end   = sel_end | end_q[i];
			end
		end
	end

	assign touched_any = |touch;
	assign mrg_start   = (sel_start < ns_q) ? sel_start : ns_q;
	assign mrg_end     = (sel_end > ne_q) ? sel_end : ne_q;

	// item outcome; checks apply to the item as received
	always_comb begin
		status_c          = ST_OK;
		inside_c          = 1'b0;
		sts.merge_pending = 1'b0;
		if (op_q == OP_QUERY) begin
			if (ns_q >= TIME_LIMIT) begin
				status_c = ST_INVALID;
			end else begin
				inside_c = |hit;
			end
		end else if (first_q && (ne_q < ns_q)) begin
			status_c = ST_ORDER;
		end else if (first_q && ((ns_q >= TIME_LIMIT) || (ne_q >= TIME_LIMIT))) begin
			status_c = ST_INVALID;
		end else if (touched_any) begin
			sts.merge_pending = 1'b1;
		end else if (first_q && (count_q >= CW'(MAX_SPANS))) begin
			status_c = ST_FULL;
		end
	end

	assign do_insert = cmd.commit && (op_q == OP_ADD) && (status_c == ST_OK);
	assign count_nx  = do_insert ? count_q + CW'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.merge) begin
			count_q <= count_q - CW'(1);
		end else begin
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			ns_q    <= in_first;
			ne_q    <= in_last;
			first_q <= 1'b1;
		end
		if (cmd.merge) begin
			// absorb the first touched span, close the gap above it
			ns_q    <= mrg_start;
			ne_q    <= mrg_end;
			first_q <= 1'b0;
			for (int i = 0; i < MAX_SPANS - 1; i++) begin
				if (!below[i]) begin
					start_q[i] <= start_q[i+1];
					end_q[i]   <= end_q[i+1];
				end
			end
		end
		if (do_insert) begin
			// open a slot at the insertion point, shift the rest up
			for (int i = 0; i < MAX_SPANS; i++) begin
				if (pos[i]) begin
					start_q[i] <= ns_q;
					end_q[i]   <= ne_q;
				end else if (i > 0 && !below[i]) begin
					start_q[i] <= start_q[i-1];
					end_q[i]   <= end_q[i-1];
				end
			end
		end
		if (cmd.commit) begin
			res_inside <= inside_c;
			res_status <= status_c;
			res_count  <= COUNT_OUT_W'(count_nx);
		end
	end

endmodule
